### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

  // Result kinds as they appear on out_kind
  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_NOQUOTE  = 3'd2,
    KIND_BADHEX   = 3'd3,
    KIND_UNCLOSED = 3'd4
  } kind_t;

  // Largest number of results one input byte produces
  localparam int MaxRes  = 3;
  localparam int CntW    = $clog2(MaxRes + 1);

  // Command queue between front and back
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  // One queued command: all results caused by one input item
  typedef struct packed {
    kind_t                    kind;
    logic [CntW-1:0]          cnt;
    logic [MaxRes-1:0][7:0]   bytes;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end: tracks the string state and turns each input item into
// one command describing the results it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          push,
  output jsu_pkg::cmd_t cmd
);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChU      = 8'h75;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_STR  = 4'b0010,
    M_ESC  = 4'b0100,
    M_HEX  = 4'b1000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [15:0] cp_shift;
  logic [4:0]  hv;
  logic [8:0]  em;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  // {valid, mapped byte}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    r = '0;
    unique case (c)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h65:   r = {1'b1, 8'h1b};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0b};
      8'h5c, 8'h22, 8'h27, 8'h3f: r = {1'b1, c};
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    cmd.kind    = jsu_pkg::KIND_BYTE;
    cmd.cnt     = '0;
    cmd.bytes   = '0;
    hv          = hex_val(in_byte);
    em          = esc_map(in_byte);
    cp_shift    = {cp_r[11:0], hv[3:0]};

    unique case (mode_r)
      M_IDLE: begin
        if (in_byte == ChQuote) begin
          mode_nxt = M_STR;
        end else begin
          cmd.kind = jsu_pkg::KIND_NOQUOTE;
          cmd.cnt  = jsu_pkg::CntW'(1);
        end
      end
      M_STR: begin
        if (in_byte == ChQuote) begin
          cmd.kind = jsu_pkg::KIND_DONE;
          cmd.cnt  = jsu_pkg::CntW'(1);
          mode_nxt = M_IDLE;
        end else if (in_byte == ChBslash) begin
          mode_nxt = M_ESC;
        end else begin
          cmd.cnt      = jsu_pkg::CntW'(1);
          cmd.bytes[0] = in_byte;
        end
      end
      M_ESC: begin
        if (in_byte == ChU) begin
          mode_nxt    = M_HEX;
          hex_cnt_nxt = '0;
          cp_nxt      = '0;
        end else begin
          // unknown escape letters are dropped
          if (em[8]) begin
            cmd.cnt      = jsu_pkg::CntW'(1);
            cmd.bytes[0] = em[7:0];
          end
          mode_nxt = M_STR;
        end
      end
      M_HEX: begin
        if (!hv[4]) begin
          cmd.kind    = jsu_pkg::KIND_BADHEX;
          cmd.cnt     = jsu_pkg::CntW'(1);
          mode_nxt    = M_IDLE;
          hex_cnt_nxt = '0;
          cp_nxt      = '0;
        end else begin
          cp_nxt = cp_shift;
          if (hex_cnt_r == 2'd3) begin
            hex_cnt_nxt = '0;
            mode_nxt    = M_STR;
            // UTF-8 encode the collected code point
            if (cp_shift <= 16'h007f) begin
              cmd.cnt      = jsu_pkg::CntW'(1);
              cmd.bytes[0] = cp_shift[7:0];
            end else if (cp_shift <= 16'h07ff) begin
              cmd.cnt      = jsu_pkg::CntW'(2);
              cmd.bytes[0] = 8'hc0 | {3'b000, cp_shift[10:6]};
              cmd.bytes[1] = 8'h80 | {2'b00, cp_shift[5:0]};
            end else begin
              cmd.cnt      = jsu_pkg::CntW'(3);
              cmd.bytes[0] = 8'he0 | {4'b0000, cp_shift[15:12]};
              cmd.bytes[1] = 8'h80 | {2'b00, cp_shift[11:6]};
              cmd.bytes[2] = 8'h80 | {2'b00, cp_shift[5:0]};
            end
          end else begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    // text ends with the string open: one unclosed result replaces the rest
    if (in_last && mode_nxt != M_IDLE) begin
      cmd.kind    = jsu_pkg::KIND_UNCLOSED;
      cmd.cnt     = jsu_pkg::CntW'(1);
      cmd.bytes   = '0;
      mode_nxt    = M_IDLE;
      hex_cnt_nxt = '0;
      cp_nxt      = '0;
    end
  end

  assign push = acc && (cmd.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      hex_cnt_r <= '0;
      cp_r      <= '0;
    end else if (acc) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small register FIFO of commands between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsu_pkg::cmd_t      wr_cmd,
  input  logic               pop,
  output jsu_pkg::cmd_t      rd_cmd,
  output jsu_pkg::q_stat_t   stat
);

  jsu_pkg::cmd_t                  mem_r [jsu_pkg::QDepth];
  logic [jsu_pkg::QPtrW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::QCntW-1:0]      cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == jsu_pkg::QCntW'(jsu_pkg::QDepth));
  assign rd_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + jsu_pkg::QCntW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - jsu_pkg::QCntW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + jsu_pkg::QPtrW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + jsu_pkg::QPtrW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output stage: unpacks each queued command into result items, one a cycle unless out_stall holds the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::cmd_t    head,
  input  jsu_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_kind,
  output logic             out_last
);

  logic                     valid_r;
  logic [7:0]               byte_r;
  logic [2:0]               kind_r;
  logic                     last_r;
  logic [jsu_pkg::CntW-1:0] idx_r;
  logic                     load;
  logic                     fin;

  // output register free or being drained this cycle
  assign load = !valid_r || !out_stall;
  assign fin  = (idx_r == head.cnt - jsu_pkg::CntW'(1));
  assign pop  = load && !stat.empty && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !stat.empty;
      if (!stat.empty) begin
        idx_r <= fin ? '0 : idx_r + jsu_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      byte_r <= head.bytes[idx_r[1:0]];
      kind_r <= head.kind;
      last_r <= fin;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule

### rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for one quoted JSON-style string literal.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while in_stall is low and produces one result
// item per cycle while out_stall is low. Ordinary bytes and simple escapes
// give one result; a \u escape gives one to three UTF-8 bytes on its fourth
// hex digit, so the output side sets the sustained rate during \u runs. A
// four-entry command queue sits between the parser and the output register;
// in_stall rises only when that queue is full. An accepted item passes
// through the queue and then the output register before its first result.
`timescale 1ns / 1ps

module json_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  jsu_pkg::cmd_t    fr_cmd, hd_cmd;
  jsu_pkg::q_stat_t q_stat;
  logic             push, pop, acc;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .cmd     (fr_cmd)
  );

  jsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (fr_cmd),
    .pop    (pop),
    .rd_cmd (hd_cmd),
    .stat   (q_stat)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (hd_cmd),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

endmodule

### rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level assertions for json_string_unescape, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [2:0] out_kind,
  input logic       out_last
);

  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_kind) && $stable(out_last), "stalled result item changed")

  `ASSERT_IMP(a_kind_range, out_valid, out_kind <= jsu_pkg::KIND_UNCLOSED, "out_kind out of range")

  `ASSERT_IMP(a_status_byte, out_valid && out_kind != jsu_pkg::KIND_BYTE, out_byte == 8'h00, "status item carries nonzero byte")

  `ASSERT_IMP(a_status_last, out_valid && out_kind != jsu_pkg::KIND_BYTE, out_last, "status item not marked last")

  // a full queue always has an item sitting in the output register
  `ASSERT_IMP(a_stall_busy, in_stall, out_valid, "input stalled with no result pending")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
